FILE: rtl/ccx_pkg.sv
`default_nettype none

package ccx_pkg;

  localparam int SAMPLE_FIELD_W  = 16;
  localparam int VALUE_W         = 32;
  localparam int CFG_DATA_W      = 63;
  localparam int SHIFT_W         = 6;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_FACTOR_BITS = 21;

  localparam logic [SHIFT_W-1:0] MAX_SHIFT   = 6'd38;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd16;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_Z = 2'd2,
    REG_SHIFT = 2'd3
  } cfg_reg_t;

  // Payload register loads, one per pipeline stage
  typedef struct packed {
    logic mult;
    logic sum;
    logic sat;
  } stage_load_t;

endpackage

`default_nettype wire

FILE: rtl/color_matrix_to_xyz_core.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata: red, green, blue samples
// m_axis    out  m_tvalid/m_tready  m_tdata: x, y, z; m_tuser: clipped
// cfg       in   cfg_we             cfg_index, cfg_data
//
// Three register stages: products, sums with rounding, shift and saturate.
// One beat can enter every cycle while the pipeline is not stalled.
// Each stage holds while the stage after it is full and stalled, so a
// stall on m_tready backs up one stage at a time with no loss.
// Reset clears stage valid bits and config registers (shift to 16).

module color_matrix_to_xyz_core #(
  parameter int SAMPLE_BITS = ccx_pkg::DEF_SAMPLE_BITS,
  parameter int FACTOR_BITS = ccx_pkg::DEF_FACTOR_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // red [15:0], green [31:16], blue [47:32]
  input  wire logic [3*ccx_pkg::SAMPLE_FIELD_W-1:0] s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // x_value [31:0], y_value [63:32], z_value [95:64]
  output logic [3*ccx_pkg::VALUE_W-1:0]            m_tdata,
  // clipped [0]
  output logic                                     m_tuser,
  input  wire logic                                cfg_we,
  input  wire ccx_pkg::cfg_reg_t                   cfg_index,
  input  wire logic [ccx_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PROD_W = FACTOR_BITS + SAMPLE_BITS + 1;
  localparam int SUM_W  = (PROD_W + 2 > 32'(ccx_pkg::MAX_SHIFT) + 2) ?
                          PROD_W + 2 : 32'(ccx_pkg::MAX_SHIFT) + 2;
  localparam int ROW_W  = 3 * FACTOR_BITS;

  logic [2:0][ROW_W-1:0]              rows;
  logic [ccx_pkg::SHIFT_W-1:0]        result_shift;
  logic [ccx_pkg::SHIFT_W-1:0]        shift_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows         <= '0;
      result_shift <= ccx_pkg::SHIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccx_pkg::REG_ROW_X: rows[0]      <= cfg_data[ROW_W-1:0];
        ccx_pkg::REG_ROW_Y: rows[1]      <= cfg_data[ROW_W-1:0];
        ccx_pkg::REG_ROW_Z: rows[2]      <= cfg_data[ROW_W-1:0];
        ccx_pkg::REG_SHIFT: result_shift <= cfg_data[ccx_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  assign shift_eff = (result_shift > ccx_pkg::MAX_SHIFT) ? ccx_pkg::MAX_SHIFT : result_shift;

  // Pipeline control
  logic                 v_mult, v_sum, v_sat;
  logic                 rdy_mult, rdy_sum, rdy_sat;
  ccx_pkg::stage_load_t load;

  assign rdy_sat  = !v_sat  || m_tready;
  assign rdy_sum  = !v_sum  || rdy_sat;
  assign rdy_mult = !v_mult || rdy_sum;
  assign s_tready = rdy_mult;

  assign load.mult = rdy_mult && s_tvalid;
  assign load.sum  = rdy_sum  && v_mult;
  assign load.sat  = rdy_sat  && v_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mult <= 1'b0;
      v_sum  <= 1'b0;
      v_sat  <= 1'b0;
    end else begin
      if (rdy_mult) begin
        v_mult <= s_tvalid;
      end
      if (rdy_sum) begin
        v_sum <= v_mult;
      end
      if (rdy_sat) begin
        v_sat <= v_sum;
      end
    end
  end

  // Datapath
  logic [2:0][SAMPLE_BITS-1:0]             samples;
  logic [2:0][2:0][PROD_W-1:0]             prod;
  logic [2:0][SUM_W-1:0]                   sum;
  logic [2:0][ccx_pkg::VALUE_W-1:0]        value;
  logic                                    clip;

  for (genvar c = 0; c < 3; c++) begin : g_sample
    assign samples[c] = s_tdata[c*ccx_pkg::SAMPLE_FIELD_W +: SAMPLE_BITS];
  end

  ccx_mult #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FACTOR_BITS (FACTOR_BITS),
    .PROD_W      (PROD_W)
  ) u_mult (
    .clk     (clk),
    .load    (load.mult),
    .rows    (rows),
    .samples (samples),
    .prod    (prod)
  );

  ccx_sum #(
    .PROD_W (PROD_W),
    .SUM_W  (SUM_W)
  ) u_sum (
    .clk   (clk),
    .load  (load.sum),
    .shift (shift_eff),
    .prod  (prod),
    .sum   (sum)
  );

  ccx_sat #(
    .SUM_W (SUM_W)
  ) u_sat (
    .clk   (clk),
    .load  (load.sat),
    .shift (shift_eff),
    .sum   (sum),
    .value (value),
    .clip  (clip)
  );

  assign m_tvalid = v_sat;
  assign m_tdata  = value;
  assign m_tuser  = clip;

  // A result beat only appears after the sum stage held one
  a_sat_from_sum: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(v_sum))
    else $error("output valid rose without a beat in the sum stage");

  // A clipped beat carries a saturation limit in at least one lane
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (m_tdata[31:0]  == 32'h7FFF_FFFF || m_tdata[31:0]  == 32'h8000_0000 ||
       m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000 ||
       m_tdata[95:64] == 32'h7FFF_FFFF || m_tdata[95:64] == 32'h8000_0000))
    else $error("clip flag set without a saturated value");

  // An accepted input beat fills the product stage
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v_mult)
    else $error("accepted beat did not reach the product stage");

  // A full product stage stalled by the next stage keeps its beat
  a_mult_hold: assert property (@(posedge clk) disable iff (rst)
    (v_mult && !rdy_sum) |=> v_mult)
    else $error("product stage dropped a stalled beat");

endmodule

`default_nettype wire

FILE: rtl/ccx_mult.sv
`default_nettype none

module ccx_mult #(
  parameter int SAMPLE_BITS = ccx_pkg::DEF_SAMPLE_BITS,
  parameter int FACTOR_BITS = ccx_pkg::DEF_FACTOR_BITS,
  parameter int PROD_W      = FACTOR_BITS + SAMPLE_BITS + 1
) (
  input  wire logic                                 clk,
  input  wire logic                                 load,
  input  wire logic [2:0][3*FACTOR_BITS-1:0]        rows,
  input  wire logic [2:0][SAMPLE_BITS-1:0]          samples,
  output logic      [2:0][2:0][PROD_W-1:0]          prod
);

  // One multiplier per matrix entry; rows index X/Y/Z, columns index R/G/B
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      logic signed [FACTOR_BITS-1:0] factor;
      logic signed [SAMPLE_BITS:0]   sample;

      assign factor = $signed(rows[r][c*FACTOR_BITS +: FACTOR_BITS]);
      assign sample = $signed({1'b0, samples[c]});

      always_ff @(posedge clk) begin
        if (load) begin
          prod[r][c] <= PROD_W'(factor * sample);
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ccx_sum.sv
`default_nettype none

module ccx_sum #(
  parameter int PROD_W = ccx_pkg::DEF_FACTOR_BITS + ccx_pkg::DEF_SAMPLE_BITS + 1,
  parameter int SUM_W  = PROD_W + 2
) (
  input  wire logic                               clk,
  input  wire logic                               load,
  input  wire logic [ccx_pkg::SHIFT_W-1:0]        shift,
  input  wire logic [2:0][2:0][PROD_W-1:0]        prod,
  output logic      [2:0][SUM_W-1:0]              sum
);

  logic signed [SUM_W-1:0] rnd;

  // Half an output LSB, so the later floor shift rounds ties upward
  always_comb begin
    if (shift == '0) begin
      rnd = '0;
    end else begin
      rnd = SUM_W'(1) << (shift - ccx_pkg::SHIFT_W'(1));
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [SUM_W-1:0] p0, p1, p2;

    assign p0 = SUM_W'($signed(prod[r][0]));
    assign p1 = SUM_W'($signed(prod[r][1]));
    assign p2 = SUM_W'($signed(prod[r][2]));

    always_ff @(posedge clk) begin
      if (load) begin
        sum[r] <= p0 + p1 + p2 + rnd;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ccx_sat.sv
`default_nettype none

module ccx_sat #(
  parameter int SUM_W = ccx_pkg::DEF_FACTOR_BITS + ccx_pkg::DEF_SAMPLE_BITS + 3
) (
  input  wire logic                                   clk,
  input  wire logic                                   load,
  input  wire logic [ccx_pkg::SHIFT_W-1:0]            shift,
  input  wire logic [2:0][SUM_W-1:0]                  sum,
  output logic      [2:0][ccx_pkg::VALUE_W-1:0]       value,
  output logic                                        clip
);

  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'($signed({1'b0, {(ccx_pkg::VALUE_W-1){1'b1}}}));
  localparam logic signed [SUM_W-1:0] SAT_LO =
    SUM_W'($signed({1'b1, {(ccx_pkg::VALUE_W-1){1'b0}}}));

  logic [2:0]                         row_clip;
  logic [2:0][ccx_pkg::VALUE_W-1:0]   row_value;

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [SUM_W-1:0] q;

    assign q = $signed(sum[r]) >>> shift;

    always_comb begin
      row_clip[r] = 1'b0;
      priority if (q > SAT_HI) begin
        row_value[r] = SAT_HI[ccx_pkg::VALUE_W-1:0];
        row_clip[r]  = 1'b1;
      end else if (q < SAT_LO) begin
        row_value[r] = SAT_LO[ccx_pkg::VALUE_W-1:0];
        row_clip[r]  = 1'b1;
      end else begin
        row_value[r] = q[ccx_pkg::VALUE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value <= row_value;
      clip  <= |row_clip;
    end
  end

endmodule

`default_nettype wire
